// ----- design/csl_pkg.sv -----
// Shared types, constants and helpers of the C subset lexer.
package csl_pkg;

	localparam int OFFSET_BITS = 16;
	localparam int OUT_BITS    = 16;
	localparam int WIDE_BITS   = (OFFSET_BITS > OUT_BITS) ? OFFSET_BITS : OUT_BITS;
	localparam int NUM_BITS    = 63;
	localparam int ACC_BITS    = NUM_BITS + 4;
	localparam int KW_NUM      = 5;
	localparam int KW_MAXLEN   = 6;
	localparam int QDEPTH      = 4;
	localparam int QPTR_BITS   = $clog2(QDEPTH);
	localparam int QCNT_BITS   = $clog2(QDEPTH + 1);

	localparam logic [NUM_BITS-1:0] NUM_MAX = {NUM_BITS{1'b1}};
	localparam logic [OUT_BITS-1:0] OUT_MAX = {OUT_BITS{1'b1}};

	localparam logic [3:0] K_OP     = 4'd0;
	localparam logic [3:0] K_IDENT  = 4'd1;
	localparam logic [3:0] K_NUM    = 4'd2;
	localparam logic [3:0] K_RETURN = 4'd3;
	localparam logic [3:0] K_IF     = 4'd4;
	localparam logic [3:0] K_ELSE   = 4'd5;
	localparam logic [3:0] K_WHILE  = 4'd6;
	localparam logic [3:0] K_FOR    = 4'd7;
	localparam logic [3:0] K_EOF    = 4'd8;
	localparam logic [3:0] K_ERR    = 4'd9;

	localparam logic [3:0] KW_KIND [KW_NUM] = '{K_RETURN, K_IF, K_ELSE, K_WHILE, K_FOR};
	localparam logic [2:0] KW_LEN  [KW_NUM] = '{3'd6, 3'd2, 3'd4, 3'd5, 3'd3};
	localparam logic [7:0] KW_TEXT [KW_NUM][KW_MAXLEN] = '{
		'{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6e},
		'{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h65, 8'h6c, 8'h73, 8'h65, 8'h00, 8'h00},
		'{8'h77, 8'h68, 8'h69, 8'h6c, 8'h65, 8'h00},
		'{8'h66, 8'h6f, 8'h72, 8'h00, 8'h00, 8'h00}
	};

	localparam logic [7:0] CH_EQ   = 8'h3d;
	localparam logic [7:0] CH_BANG = 8'h21;
	localparam logic [7:0] CH_LT   = 8'h3c;
	localparam logic [7:0] CH_GT   = 8'h3e;
	localparam logic [7:0] CH_ZERO = 8'h30;

	typedef struct packed {
		logic [3:0]          kind;
		logic [OUT_BITS-1:0] start_offset;
		logic [OUT_BITS-1:0] token_length;
		logic [NUM_BITS-1:0] number_value;
		logic [7:0]          op_first;
		logic [7:0]          op_second;
		logic                last_of_run;
	} token_t;

	typedef struct packed {
		logic [1:0] n;
		token_t     t0;
		token_t     t1;
	} push_t;

	function automatic logic [OUT_BITS-1:0] out_sat(input logic [OFFSET_BITS-1:0] v);
		logic [WIDE_BITS-1:0] w;
		w = WIDE_BITS'(v);
		out_sat = (w > WIDE_BITS'(OUT_MAX)) ? OUT_MAX : w[OUT_BITS-1:0];
	endfunction

endpackage

// ----- design/csl_if.sv -----
// Handshake channels of the lexer: character items in, token items out.
interface csl_in_if import csl_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] ch;

	modport source (output valid, action, ch, input ready);
	modport sink (input valid, action, ch, output ready);
endinterface

interface csl_out_if import csl_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [3:0]          kind;
	logic [OUT_BITS-1:0] start_offset;
	logic [OUT_BITS-1:0] token_length;
	logic [NUM_BITS-1:0] number_value;
	logic [7:0]          op_first;
	logic [7:0]          op_second;
	logic                last_of_run;

	modport source (output valid, kind, start_offset, token_length, number_value, op_first,
		op_second, last_of_run, input ready);
	modport sink (input valid, kind, start_offset, token_length, number_value, op_first,
		op_second, last_of_run, output ready);
endinterface

// ----- design/c_subset_lexer.sv -----
// Top level of the C subset lexer: scanner front end feeding the token queue.
//
//   channel  dir  payload                                        handshake
//   chars    in   action, ch                                     valid/ready
//   tokens   out  kind, start_offset, token_length,               valid/ready
//                 number_value, op_first, op_second, last_of_run
//
// One character item per cycle while chars.ready is high; the scanner state is registered per item.
// Each item yields zero to two tokens; the output drains one token per cycle while tokens.ready is high.
// chars.ready drops while the four-entry token queue has fewer than two free slots.
// Tokens pass through the queue memory and then the output register before they reach the output.
// Reset returns the scanner to idle and empties the queue; no clearing pass.
module c_subset_lexer import csl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	csl_in_if.sink    chars,
	csl_out_if.source tokens
);

	push_t push;
	logic  space_ok;

	csl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.chars    (chars),
		.space_ok (space_ok),
		.push     (push)
	);

	csl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.space_ok (space_ok),
		.tokens   (tokens)
	);

endmodule

// ----- design/csl_front.sv -----
// Lexer front end: scan state per character, builds up to two tokens per item.
module csl_front import csl_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	csl_in_if.sink       chars,
	input  logic         space_ok,
	output push_t        push
);

	typedef enum logic [3:0] {
		M_IDLE = 4'b0001,
		M_WORD = 4'b0010,
		M_NUM  = 4'b0100,
		M_OP   = 4'b1000
	} mode_t;

	mode_t                  mode_q, mode_d;
	logic [7:0]             held_q, held_d;
	logic [OFFSET_BITS-1:0] start_q, start_d;
	logic [OFFSET_BITS-1:0] count_q, count_d;
	logic [NUM_BITS-1:0]    acc_q, acc_d;
	logic [KW_NUM-1:0]      cand_q, cand_d;
	logic [OFFSET_BITS-1:0] pos_q, pos_d;
	logic                   discard_q, discard_d;

	logic       accept;
	logic [7:0] c;
	logic       a_v, b_v, go;
	token_t     a_tok, b_tok;
	logic [ACC_BITS-1:0] acc_wide;

	function automatic logic is_lower(input logic [7:0] x);
		is_lower = (x >= 8'h61) && (x <= 8'h7a);
	endfunction

	function automatic logic is_digit(input logic [7:0] x);
		is_digit = (x >= 8'h30) && (x <= 8'h39);
	endfunction

	function automatic logic is_space(input logic [7:0] x);
		is_space = (x == 8'h20) || ((x >= 8'h09) && (x <= 8'h0d));
	endfunction

	function automatic logic is_alnum_us(input logic [7:0] x);
		is_alnum_us = is_lower(x) || ((x >= 8'h41) && (x <= 8'h5a)) || is_digit(x) ||
			(x == 8'h5f);
	endfunction

	function automatic logic is_plain_op(input logic [7:0] x);
		is_plain_op = (x == 8'h2b) || (x == 8'h2d) || (x == 8'h2a) || (x == 8'h2f) ||
			(x == 8'h28) || (x == 8'h29) || (x == 8'h3b) || (x == 8'h7b) || (x == 8'h7d);
	endfunction

	function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
		sat_inc = (v == {OFFSET_BITS{1'b1}}) ? v : v + 1'b1;
	endfunction

	function automatic logic [KW_NUM-1:0] cand_step(input logic [KW_NUM-1:0] cand,
		input logic [OFFSET_BITS-1:0] cnt, input logic [7:0] x);
		logic [KW_NUM-1:0] r;
		r = '0;
		for (int i = 0; i < KW_NUM; i++) begin
			r[i] = cand[i] && (cnt < OFFSET_BITS'(KW_LEN[i])) &&
				(KW_TEXT[i][cnt[2:0]] == x);
		end
		cand_step = r;
	endfunction

	function automatic token_t mk_tok(input logic [3:0] kind, input logic [OUT_BITS-1:0] st,
		input logic [OUT_BITS-1:0] len, input logic [NUM_BITS-1:0] val,
		input logic [7:0] op1, input logic [7:0] op2);
		token_t t;
		t.kind         = kind;
		t.start_offset = st;
		t.token_length = len;
		t.number_value = val;
		t.op_first     = op1;
		t.op_second    = op2;
		t.last_of_run  = 1'b0;
		mk_tok = t;
	endfunction

	function automatic token_t word_tok(input logic [KW_NUM-1:0] cand,
		input logic [OFFSET_BITS-1:0] cnt, input logic [OFFSET_BITS-1:0] st,
		input logic next_alnum);
		logic [3:0] kind;
		kind = K_IDENT;
		if (!next_alnum) begin
			for (int i = 0; i < KW_NUM; i++) begin
				if (cand[i] && (cnt == OFFSET_BITS'(KW_LEN[i]))) begin
					kind = KW_KIND[i];
				end
			end
		end
		word_tok = mk_tok(kind, out_sat(st), out_sat(cnt), '0, 8'h00, 8'h00);
	endfunction

	assign c           = chars.ch;
	assign chars.ready = space_ok;
	assign accept      = chars.valid && space_ok;
	assign acc_wide    = (ACC_BITS'(acc_q) << 3) + (ACC_BITS'(acc_q) << 1) +
		ACC_BITS'(c - CH_ZERO);

	always_comb begin
		mode_d    = mode_q;
		held_d    = held_q;
		start_d   = start_q;
		count_d   = count_q;
		acc_d     = acc_q;
		cand_d    = cand_q;
		pos_d     = pos_q;
		discard_d = discard_q;
		a_v       = 1'b0;
		a_tok     = '0;
		b_v       = 1'b0;
		b_tok     = '0;
		go        = 1'b0;
		if (chars.action) begin
			if (!discard_q) begin
				case (mode_q)
					M_WORD: begin
						a_v   = 1'b1;
						a_tok = word_tok(cand_q, count_q, start_q, 1'b0);
					end
					M_NUM: begin
						a_v   = 1'b1;
						a_tok = mk_tok(K_NUM, out_sat(start_q), '0, acc_q, 8'h00, 8'h00);
					end
					M_OP: begin
						a_v = 1'b1;
						if (held_q == CH_BANG) begin
							a_tok = mk_tok(K_ERR, out_sat(start_q), OUT_BITS'(1), '0, 8'h00,
								8'h00);
						end else begin
							a_tok = mk_tok(K_OP, out_sat(start_q), OUT_BITS'(1), '0, held_q,
								8'h00);
						end
					end
					default: ;
				endcase
			end
			b_v       = 1'b1;
			b_tok     = mk_tok(K_EOF, out_sat(pos_q), '0, '0, 8'h00, 8'h00);
			mode_d    = M_IDLE;
			held_d    = '0;
			start_d   = '0;
			count_d   = '0;
			acc_d     = '0;
			cand_d    = '1;
			pos_d     = '0;
			discard_d = 1'b0;
		end else if (discard_q) begin
			pos_d = sat_inc(pos_q);
		end else begin
			go = 1'b1;
			case (mode_q)
				M_WORD: begin
					if (is_lower(c)) begin
						go      = 1'b0;
						cand_d  = cand_step(cand_q, count_q, c);
						count_d = sat_inc(count_q);
					end else begin
						a_v    = 1'b1;
						a_tok  = word_tok(cand_q, count_q, start_q, is_alnum_us(c));
						mode_d = M_IDLE;
					end
				end
				M_NUM: begin
					if (is_digit(c)) begin
						go    = 1'b0;
						acc_d = (acc_wide > ACC_BITS'(NUM_MAX)) ? NUM_MAX :
							acc_wide[NUM_BITS-1:0];
					end else begin
						a_v    = 1'b1;
						a_tok  = mk_tok(K_NUM, out_sat(start_q), '0, acc_q, 8'h00, 8'h00);
						mode_d = M_IDLE;
					end
				end
				M_OP: begin
					mode_d = M_IDLE;
					a_v    = 1'b1;
					if (c == CH_EQ) begin
						go    = 1'b0;
						a_tok = mk_tok(K_OP, out_sat(start_q), OUT_BITS'(2), '0, held_q, CH_EQ);
					end else if (held_q == CH_BANG) begin
						go        = 1'b0;
						discard_d = 1'b1;
						a_tok     = mk_tok(K_ERR, out_sat(start_q), OUT_BITS'(1), '0, 8'h00,
							8'h00);
					end else begin
						a_tok = mk_tok(K_OP, out_sat(start_q), OUT_BITS'(1), '0, held_q, 8'h00);
					end
				end
				default: ;
			endcase
			if (go && !is_space(c)) begin
				if (is_lower(c)) begin
					mode_d  = M_WORD;
					start_d = pos_q;
					cand_d  = cand_step('1, '0, c);
					count_d = OFFSET_BITS'(1);
				end else if (is_digit(c)) begin
					mode_d  = M_NUM;
					start_d = pos_q;
					acc_d   = NUM_BITS'(c - CH_ZERO);
				end else if ((c == CH_EQ) || (c == CH_LT) || (c == CH_GT) || (c == CH_BANG)) begin
					mode_d  = M_OP;
					held_d  = c;
					start_d = pos_q;
				end else if (is_plain_op(c)) begin
					b_v   = 1'b1;
					b_tok = mk_tok(K_OP, out_sat(pos_q), OUT_BITS'(1), '0, c, 8'h00);
				end else begin
					b_v       = 1'b1;
					b_tok     = mk_tok(K_ERR, out_sat(pos_q), OUT_BITS'(1), '0, 8'h00, 8'h00);
					discard_d = 1'b1;
				end
			end
			pos_d = sat_inc(pos_q);
		end
	end

	always_comb begin
		push.n  = accept ? (2'(a_v) + 2'(b_v)) : 2'd0;
		push.t0 = a_v ? a_tok : b_tok;
		push.t1 = b_tok;
		if (a_v && b_v) begin
			push.t1.last_of_run = 1'b1;
		end else begin
			push.t0.last_of_run = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= M_IDLE;
			held_q    <= '0;
			start_q   <= '0;
			count_q   <= '0;
			acc_q     <= '0;
			cand_q    <= '1;
			pos_q     <= '0;
			discard_q <= 1'b0;
		end else if (accept) begin
			mode_q    <= mode_d;
			held_q    <= held_d;
			start_q   <= start_d;
			count_q   <= count_d;
			acc_q     <= acc_d;
			cand_q    <= cand_d;
			pos_q     <= pos_d;
			discard_q <= discard_d;
		end
	end

endmodule

// ----- design/csl_queue.sv -----
// Token queue and output register: takes up to two tokens per cycle, emits one per cycle while tokens.ready is high.
module csl_queue import csl_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  push_t         push,
	output logic          space_ok,
	csl_out_if.source     tokens
);

	token_t                 mem_q [QDEPTH];
	logic [QPTR_BITS-1:0]   wr_q, rd_q;
	logic [QCNT_BITS-1:0]   cnt_q;
	logic                   pop;
	logic                   out_valid_q;
	token_t                 out_q;

	assign space_ok = cnt_q <= QCNT_BITS'(QDEPTH - 2);
	assign pop      = (cnt_q != '0) && (!out_valid_q || tokens.ready);

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_q] <= push.t0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_q + 1'b1] <= push.t1;
		end
		if (pop) begin
			out_q <= mem_q[rd_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q        <= '0;
			rd_q        <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			wr_q  <= wr_q + QPTR_BITS'(push.n);
			rd_q  <= rd_q + QPTR_BITS'(pop);
			cnt_q <= cnt_q + QCNT_BITS'(push.n) - QCNT_BITS'(pop);
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (tokens.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign tokens.valid        = out_valid_q;
	assign tokens.kind         = out_q.kind;
	assign tokens.start_offset = out_q.start_offset;
	assign tokens.token_length = out_q.token_length;
	assign tokens.number_value = out_q.number_value;
	assign tokens.op_first     = out_q.op_first;
	assign tokens.op_second    = out_q.op_second;
	assign tokens.last_of_run  = out_q.last_of_run;

endmodule

// ----- dv/c_subset_lexer_tb.sv -----
// Self-checking testbench for the C subset lexer: directed table, random texts, token scoreboard.
module c_subset_lexer_tb import csl_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {SCAN_IDLE, SCAN_WORD, SCAN_NUM, SCAN_OP} scan_e;

	typedef struct packed {
		logic                act;
		logic [7:0]          c;
		logic                chk;
		logic [3:0]          kind;
		logic [OUT_BITS-1:0] start;
		logic [OUT_BITS-1:0] len;
		logic [NUM_BITS-1:0] val;
		logic [7:0]          op1;
		logic [7:0]          op2;
	} row_t;

	localparam row_t DIRECTED [23] = '{
		'{0, "w", 0, 0, 0, 0, 0, 0, 0},
		'{0, "h", 0, 0, 0, 0, 0, 0, 0},
		'{0, "i", 0, 0, 0, 0, 0, 0, 0},
		'{0, "l", 0, 0, 0, 0, 0, 0, 0},
		'{0, "e", 0, 0, 0, 0, 0, 0, 0},
		'{0, "!", 1, K_WHILE, 0, 5, 0, 0, 0},
		'{0, "=", 1, K_OP, 5, 2, 0, "!", "="},
		'{0, "9", 0, 0, 0, 0, 0, 0, 0},
		'{0, "<", 1, K_NUM, 7, 0, 9, 0, 0},
		'{0, " ", 1, K_OP, 8, 1, 0, "<", 0},
		'{0, "!", 0, 0, 0, 0, 0, 0, 0},
		'{0, "x", 1, K_ERR, 10, 1, 0, 0, 0},
		'{0, 8'hff, 0, 0, 0, 0, 0, 0, 0},
		'{1, 8'h00, 1, K_EOF, 13, 0, 0, 0, 0},
		'{0, 8'h00, 1, K_ERR, 0, 1, 0, 0, 0},
		'{1, 8'hff, 1, K_EOF, 1, 0, 0, 0, 0},
		'{0, "f", 0, 0, 0, 0, 0, 0, 0},
		'{0, "o", 0, 0, 0, 0, 0, 0, 0},
		'{0, "r", 0, 0, 0, 0, 0, 0, 0},
		'{0, "_", 1, K_ERR, 3, 1, 0, 0, 0},
		'{1, 8'h5a, 1, K_EOF, 4, 0, 0, 0, 0},
		'{0, "=", 0, 0, 0, 0, 0, 0, 0},
		'{1, 8'h80, 1, K_EOF, 1, 0, 0, 0, 0}
	};

	logic clk;
	logic arst_n;

	csl_in_if  chars();
	csl_out_if tokens();

	c_subset_lexer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.tokens (tokens)
	);

	string kw_word [KW_NUM] = '{"return", "if", "else", "while", "for"};

	scan_e                  lx_mode;
	logic [7:0]             lx_held;
	logic [OFFSET_BITS-1:0] lx_start;
	logic [OFFSET_BITS-1:0] lx_count;
	logic [OFFSET_BITS-1:0] lx_pos;
	logic [NUM_BITS-1:0]    lx_acc;
	logic [KW_NUM-1:0]      lx_kw;
	bit                     lx_drop;

	token_t     step_tokens[$];
	token_t     pending_tokens[$];
	logic [7:0] txt[$];
	bit         quiet;
	int         n_errors;
	int         n_items;
	int         n_texts;
	int         n_checked;
	int         stall;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("c_subset_lexer_tb: done, errors");
		$finish;
	end

	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 65)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	function automatic logic [7:0] ws_char();
		return ($urandom_range(0, 2) == 0) ? 8'(" ") : 8'($urandom_range(9, 13));
	endfunction

	function automatic logic [OFFSET_BITS-1:0] bump(input logic [OFFSET_BITS-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic logic [OUT_BITS-1:0] clip(input logic [OFFSET_BITS-1:0] v);
		longint unsigned w;
		w = v;
		return (w > OUT_MAX) ? OUT_MAX : OUT_BITS'(w);
	endfunction

	function automatic bit is_lower(input logic [7:0] c);
		return c >= "a" && c <= "z";
	endfunction

	function automatic bit is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic void push_tok(input logic [3:0] kind, input logic [OFFSET_BITS-1:0] start,
		input logic [OFFSET_BITS-1:0] len, input logic [NUM_BITS-1:0] val,
		input logic [7:0] op1, input logic [7:0] op2);
		token_t t;
		t.kind         = kind;
		t.start_offset = clip(start);
		t.token_length = clip(len);
		t.number_value = val;
		t.op_first     = op1;
		t.op_second    = op2;
		t.last_of_run  = 1'b0;
		step_tokens.push_back(t);
	endfunction

	function automatic void clear_state();
		lx_mode  = SCAN_IDLE;
		lx_held  = '0;
		lx_start = '0;
		lx_count = '0;
		lx_acc   = '0;
		lx_kw    = '1;
		lx_pos   = '0;
		lx_drop  = 1'b0;
	endfunction

	function automatic void take_letter(input logic [7:0] c);
		for (int i = 0; i < KW_NUM; i++)
			if (lx_kw[i] && !(lx_count < kw_word[i].len() && kw_word[i][lx_count] == c))
				lx_kw[i] = 1'b0;
		lx_count = bump(lx_count);
	endfunction

	function automatic void flush_word(input bit next_alnum);
		logic [3:0] kind;
		kind = K_IDENT;
		if (!next_alnum)
			for (int i = 0; i < KW_NUM; i++)
				if (lx_kw[i] && lx_count == kw_word[i].len())
					kind = K_RETURN + 4'(i);
		push_tok(kind, lx_start, 0, 0, 0, 0);
		step_tokens[step_tokens.size()-1].token_length = clip(lx_count);
		lx_mode = SCAN_IDLE;
	endfunction

	function automatic void lex_char(input logic act, input logic [7:0] c);
		bit          held;
		bit          used;
		logic [63:0] d;
		held = 1'b0;
		used = 1'b0;
		step_tokens.delete();
		if (act) begin
			if (!lx_drop) begin
				case (lx_mode)
					SCAN_WORD: flush_word(1'b0);
					SCAN_NUM:  push_tok(K_NUM, lx_start, 0, lx_acc, 0, 0);
					SCAN_OP: begin
						if (lx_held == CH_BANG)
							push_tok(K_ERR, lx_start, 1, 0, 0, 0);
						else
							push_tok(K_OP, lx_start, 1, 0, lx_held, 0);
					end
					default: ;
				endcase
			end
			push_tok(K_EOF, lx_pos, 0, 0, 0, 0);
			clear_state();
		end else if (lx_drop) begin
			lx_pos = bump(lx_pos);
		end else begin
			case (lx_mode)
				SCAN_WORD: begin
					if (is_lower(c)) begin
						take_letter(c);
						held = 1'b1;
					end else begin
						flush_word((c >= "A" && c <= "Z") || is_digit(c) || c == "_");
					end
				end
				SCAN_NUM: begin
					if (is_digit(c)) begin
						d = 64'(c - CH_ZERO);
						if (64'(lx_acc) > (64'(NUM_MAX) - d) / 10)
							lx_acc = NUM_MAX;
						else
							lx_acc = NUM_BITS'(64'(lx_acc) * 10 + d);
						held = 1'b1;
					end else begin
						push_tok(K_NUM, lx_start, 0, lx_acc, 0, 0);
						lx_mode = SCAN_IDLE;
					end
				end
				SCAN_OP: begin
					lx_mode = SCAN_IDLE;
					if (c == CH_EQ) begin
						push_tok(K_OP, lx_start, 2, 0, lx_held, CH_EQ);
						used = 1'b1;
					end else if (lx_held == CH_BANG) begin
						push_tok(K_ERR, lx_start, 1, 0, 0, 0);
						lx_drop = 1'b1;
						used = 1'b1;
					end else begin
						push_tok(K_OP, lx_start, 1, 0, lx_held, 0);
					end
				end
				default: ;
			endcase
			if (!held && !used && !(c == " " || (c >= 8'd9 && c <= 8'd13))) begin
				if (is_lower(c)) begin
					lx_mode  = SCAN_WORD;
					lx_start = lx_pos;
					lx_count = '0;
					lx_kw    = '1;
					take_letter(c);
				end else if (is_digit(c)) begin
					lx_mode  = SCAN_NUM;
					lx_start = lx_pos;
					lx_acc   = NUM_BITS'(c - CH_ZERO);
				end else if (c inside {CH_EQ, CH_LT, CH_GT, CH_BANG}) begin
					lx_mode  = SCAN_OP;
					lx_held  = c;
					lx_start = lx_pos;
				end else if (c inside {"+", "-", "*", "/", "(", ")", ";", "{", "}"}) begin
					push_tok(K_OP, lx_pos, 1, 0, c, 0);
				end else begin
					push_tok(K_ERR, lx_pos, 1, 0, 0, 0);
					lx_drop = 1'b1;
				end
			end
			lx_pos = bump(lx_pos);
		end
		if (step_tokens.size() > 0)
			step_tokens[step_tokens.size()-1].last_of_run = 1'b1;
		foreach (step_tokens[i])
			pending_tokens.push_back(step_tokens[i]);
	endfunction

	function automatic void cmp_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			n_errors++;
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
		end
	endfunction

	task automatic send_char(input logic a, input logic [7:0] c);
		int gap;
		gap = pick_idle();
		if (gap > 0) begin
			chars.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chars.valid  <= 1'b1;
		chars.action <= a;
		chars.ch     <= c;
		do @(posedge clk); while (!chars.ready);
		n_items++;
		lex_char(a, c);
	endtask

	task automatic drain();
		chars.valid <= 1'b0;
		do @(posedge clk); while (pending_tokens.size() != 0);
	endtask

	task automatic send_text(input bit hold_mid);
		foreach (txt[i]) begin
			send_char(1'b0, txt[i]);
			if (hold_mid && i == txt.size() / 2)
				drain();
		end
		send_char(1'b1, 8'($urandom_range(0, 255)));
		n_texts++;
	endtask

	task automatic build_text();
		int    nfrag;
		int    r;
		int    len;
		string w;
		string ops1 = "+-*/<>()=;{}";
		string ops2 = "=!<>";
		txt.delete();
		nfrag = $urandom_range(2, 14);
		for (int f = 0; f < nfrag; f++) begin
			r = $urandom_range(0, 99);
			if (r < 14) begin
				w = kw_word[$urandom_range(0, KW_NUM - 1)];
				len = w.len();
				r = $urandom_range(0, 9);
				if (r < 2)
					len = $urandom_range(1, w.len());
				for (int k = 0; k < len; k++)
					txt.push_back(w[k]);
				if (r >= 8)
					repeat ($urandom_range(1, 3)) txt.push_back(8'($urandom_range("a", "z")));
			end else if (r < 34) begin
				repeat ($urandom_range(1, 8)) txt.push_back(8'($urandom_range("a", "z")));
			end else if (r < 50) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(18, 22) : $urandom_range(1, 5);
				repeat (len) txt.push_back(8'($urandom_range("0", "9")));
			end else if (r < 76) begin
				r = $urandom_range(0, 9);
				if (r < 3) begin
					txt.push_back(ops2[$urandom_range(0, 3)]);
					txt.push_back(CH_EQ);
				end else if (r < 9) begin
					txt.push_back(ops1[$urandom_range(0, 11)]);
				end else begin
					txt.push_back(CH_BANG);
				end
			end else if (r < 78) begin
				txt.push_back(8'($urandom_range(0, 255)));
			end
			if ($urandom_range(0, 99) < 55)
				repeat ($urandom_range(1, 2)) txt.push_back(ws_char());
		end
	endtask

	initial begin
		tokens.ready = 1'b0;
		stall = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (tokens.valid && tokens.ready) begin
				if (pending_tokens.size() == 0) begin
					n_errors++;
					$display("%0t: token kind %0d at %0d arrived with none expected",
						$time, tokens.kind, tokens.start_offset);
				end else begin
					n_checked++;
					cmp_field("kind", pending_tokens[0].kind, tokens.kind);
					cmp_field("start_offset", pending_tokens[0].start_offset, tokens.start_offset);
					cmp_field("token_length", pending_tokens[0].token_length, tokens.token_length);
					cmp_field("number_value", pending_tokens[0].number_value, tokens.number_value);
					cmp_field("op_first", pending_tokens[0].op_first, tokens.op_first);
					cmp_field("op_second", pending_tokens[0].op_second, tokens.op_second);
					cmp_field("last_of_run", pending_tokens[0].last_of_run, tokens.last_of_run);
					void'(pending_tokens.pop_front());
				end
			end
			if (stall > 0) begin
				stall--;
				tokens.ready <= 1'b0;
			end else begin
				stall = pick_idle();
				tokens.ready <= (stall == 0);
				if (stall > 0)
					stall--;
			end
		end
	end

	initial begin
		row_t   row;
		token_t last;
		arst_n       = 1'b0;
		chars.valid  = 1'b0;
		chars.action = 1'b0;
		chars.ch     = 8'h00;
		quiet        = 1'b0;
		n_errors     = 0;
		n_items      = 0;
		n_texts      = 0;
		n_checked    = 0;
		clear_state();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < $size(DIRECTED); r++) begin
			row = DIRECTED[r];
			send_char(row.act, row.c);
			if (row.chk) begin
				last = (step_tokens.size() > 0) ? step_tokens[step_tokens.size()-1] : '0;
				if (step_tokens.size() == 0 || last.kind != row.kind ||
					last.start_offset != row.start || last.token_length != row.len ||
					last.number_value != row.val || last.op_first != row.op1 ||
					last.op_second != row.op2) begin
					n_errors++;
					$display("%0t: row %0d expected kind %0d start %0d len %0d value %0d op %0h %0h",
						$time, r, row.kind, row.start, row.len, row.val, row.op1, row.op2);
					$display("%0t: row %0d got kind %0d start %0d len %0d value %0d op %0h %0h",
						$time, r, last.kind, last.start_offset, last.token_length,
						last.number_value, last.op_first, last.op_second);
				end
			end
		end
		drain();

		while (n_items < 1650) begin
			quiet = ($urandom_range(0, 4) == 0);
			build_text();
			send_text(n_texts % 7 == 3);
		end
		quiet = 1'b0;

		drain();
		repeat (20) @(posedge clk);
		if (pending_tokens.size() != 0) begin
			n_errors++;
			$display("%0t: %0d expected tokens never arrived", $time, pending_tokens.size());
		end
		$display("%0d character items in %0d texts, %0d tokens compared", n_items, n_texts,
			n_checked);
		$display("covered keywords and prefixes, operators, saturating numbers, bad bytes");
		if (n_errors == 0)
			$display("c_subset_lexer_tb: done, clean");
		else
			$display("c_subset_lexer_tb: done, errors");
		$finish;
	end

endmodule

// ----- c_subset_lexer.f -----
design/csl_pkg.sv
design/csl_if.sv
design/csl_front.sv
design/csl_queue.sv
design/c_subset_lexer.sv
dv/c_subset_lexer_tb.sv
